// File: rtl/strict_utf8_stream_decoder_assert.svh
`ifndef STRICT_UTF8_STREAM_DECODER_ASSERT_SVH
`define STRICT_UTF8_STREAM_DECODER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define UTF8D_ASSERT_SAME(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define UTF8D_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/utf8d_pkg.sv
package utf8d_pkg;

	localparam logic [20:0] REPL_CP  = 21'h00FFFD;
	localparam logic [20:0] MAX_CP   = 21'h10FFFF;
	localparam logic [20:0] SURR_LO  = 21'h00D800;
	localparam logic [20:0] SURR_HI  = 21'h00DFFF;
	localparam logic [20:0] MIN_CP2  = 21'h000080;
	localparam logic [20:0] MIN_CP3  = 21'h000800;
	localparam logic [20:0] MIN_CP4  = 21'h010000;

	localparam int QUEUE_DEPTH = 4;

	// Work for the back end from one byte: n_repl replacements, then an
	// optional decoded value.
	typedef struct packed {
		logic [2:0]  n_repl;
		logic        has_val;
		logic [20:0] val_cp;
		logic [2:0]  val_len;
	} desc_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

endpackage

// File: rtl/utf8d_front.sv
module utf8d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              end_of_stream,
	output logic              enq,
	output utf8d_pkg::desc_t  desc,
	output logic              pending
);

	logic [2:0]  exp_len_q, exp_len_d;
	logic [1:0]  seen_q, seen_d;
	logic [20:0] part_q, part_d;
	logic [20:0] r_val;
	logic [20:0] least;
	logic [2:0]  seen_inc;
	logic        is_cont;
	logic        r_bad;
	logic        do_start;

	assign is_cont  = (data_byte[7:6] == 2'b10);
	assign r_val    = {part_q[14:0], data_byte[5:0]};
	assign seen_inc = {1'b0, seen_q} + 3'd1;

	always_comb begin
		unique case (exp_len_q)
			3'd2:    least = utf8d_pkg::MIN_CP2;
			3'd3:    least = utf8d_pkg::MIN_CP3;
			default: least = utf8d_pkg::MIN_CP4;
		endcase
	end

	assign r_bad = (r_val < least) || (r_val > utf8d_pkg::MAX_CP) ||
		((r_val >= utf8d_pkg::SURR_LO) && (r_val <= utf8d_pkg::SURR_HI));

	always_comb begin
		desc      = '0;
		exp_len_d = exp_len_q;
		seen_d    = seen_q;
		part_d    = part_q;
		do_start  = 1'b0;

		if (exp_len_q == 3'd0) begin
			do_start = 1'b1;
		end else if (is_cont) begin
			if (seen_inc >= exp_len_q) begin
				if (r_bad) begin
					desc.n_repl = exp_len_q;
				end else begin
					desc.has_val = 1'b1;
					desc.val_cp  = r_val;
					desc.val_len = exp_len_q;
				end
				exp_len_d = 3'd0;
				seen_d    = 2'd0;
				part_d    = '0;
			end else begin
				seen_d = seen_inc[1:0];
				part_d = r_val;
			end
		end else begin
			// broken sequence: replace what was taken, then decode this byte afresh
			desc.n_repl = {1'b0, seen_q};
			exp_len_d   = 3'd0;
			seen_d      = 2'd0;
			part_d      = '0;
			do_start    = 1'b1;
		end

		if (do_start) begin
			priority if (!data_byte[7]) begin
				desc.has_val = 1'b1;
				desc.val_cp  = {13'd0, data_byte};
				desc.val_len = 3'd1;
			end else if (data_byte[7:5] == 3'b110) begin
				exp_len_d = 3'd2;
				seen_d    = 2'd1;
				part_d    = {16'd0, data_byte[4:0]};
			end else if (data_byte[7:4] == 4'b1110) begin
				exp_len_d = 3'd3;
				seen_d    = 2'd1;
				part_d    = {17'd0, data_byte[3:0]};
			end else if (data_byte[7:3] == 5'b11110) begin
				exp_len_d = 3'd4;
				seen_d    = 2'd1;
				part_d    = {18'd0, data_byte[2:0]};
			end else begin
				desc.n_repl = desc.n_repl + 3'd1;
			end
		end

		// flush whatever is still pending at end of stream
		if (end_of_stream && (exp_len_d != 3'd0)) begin
			desc.n_repl = desc.n_repl + {1'b0, seen_d};
			exp_len_d   = 3'd0;
			seen_d      = 2'd0;
			part_d      = '0;
		end
	end

	assign enq     = accept && ((desc.n_repl != 3'd0) || desc.has_val);
	assign pending = (exp_len_q != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= 3'd0;
			seen_q    <= 2'd0;
			part_q    <= '0;
		end else if (accept) begin
			exp_len_q <= exp_len_d;
			seen_q    <= seen_d;
			part_q    <= part_d;
		end
	end

endmodule

// File: rtl/utf8d_queue.sv
module utf8d_queue #(
	parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               enq,
	input  utf8d_pkg::desc_t   enq_desc,
	input  logic               deq,
	output utf8d_pkg::desc_t   head,
	output utf8d_pkg::q_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	utf8d_pkg::desc_t  slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_enq;
	logic              do_deq;

	assign stat.not_empty = (cnt_q != '0);
	assign stat.full      = (cnt_q == CNT_W'(DEPTH));
	assign do_enq         = enq && !stat.full;
	assign do_deq         = deq && stat.not_empty;
	assign head           = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_enq) begin
			slot_q[wr_ptr_q] <= enq_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_enq) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_enq && !do_deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_deq && !do_enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/utf8d_back.sv
module utf8d_back (
	input  logic               clk,
	input  logic               arst_n,
	input  utf8d_pkg::desc_t   head,
	input  utf8d_pkg::q_stat_t stat,
	output logic               deq,
	input  logic               pop,
	output logic               empty,
	output logic [20:0]        code_point,
	output logic               replaced,
	output logic [2:0]         byte_count,
	output logic               last_of_run
);

	logic [2:0] idx_q;
	logic [2:0] total;
	logic       is_last;
	logic       load;
	logic       out_v_q;
	logic       take;

	assign total   = head.n_repl + {2'b00, head.has_val};
	assign is_last = ((idx_q + 3'd1) == total);
	assign take    = pop && out_v_q;
	assign load    = stat.not_empty && (!out_v_q || take);
	assign deq     = load && is_last;
	assign empty   = !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			idx_q   <= 3'd0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				idx_q   <= is_last ? 3'd0 : idx_q + 3'd1;
			end else if (take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// replacements go out first, the decoded value last
	always_ff @(posedge clk) begin
		if (load) begin
			if (idx_q < head.n_repl) begin
				code_point <= utf8d_pkg::REPL_CP;
				replaced   <= 1'b1;
				byte_count <= 3'd1;
			end else begin
				code_point <= head.val_cp;
				replaced   <= 1'b0;
				byte_count <= head.val_len;
			end
			last_of_run <= is_last;
		end
	end

endmodule

// File: rtl/strict_utf8_stream_decoder.sv
// The first word caused by an accepted byte is written into the queue and then loaded into the
// output register; each further word from the same byte is loaded once the one before is popped.
// Throughput: one byte per cycle while the queue is not full and bytes give at most one word each;
// the back end emits one word per cycle while words are popped, so bytes giving several words drain through the queue.
// Reset: arst_n clears the pending sequence, the queue and the output valid flag.
`include "strict_utf8_stream_decoder_assert.svh"

module strict_utf8_stream_decoder #(
	parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output logic        empty,
	input  logic        pop,
	output logic [20:0] code_point,
	output logic        replaced,
	output logic [2:0]  byte_count,
	output logic        last_of_run
);

	utf8d_pkg::desc_t   desc;
	utf8d_pkg::desc_t   head;
	utf8d_pkg::q_stat_t stat;
	logic               accept;
	logic               enq;
	logic               deq;
	logic               pending;

	assign full   = stat.full;
	assign accept = push && !stat.full;

	utf8d_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.enq           (enq),
		.desc          (desc),
		.pending       (pending)
	);

	utf8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.enq      (enq),
		.enq_desc (desc),
		.deq      (deq),
		.head     (head),
		.stat     (stat)
	);

	utf8d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.stat        (stat),
		.deq         (deq),
		.pop         (pop),
		.empty       (empty),
		.code_point  (code_point),
		.replaced    (replaced),
		.byte_count  (byte_count),
		.last_of_run (last_of_run)
	);

	`UTF8D_ASSERT_SAME(a_repl_form, !empty && replaced, (code_point == utf8d_pkg::REPL_CP) && (byte_count == 3'd1), "replacement word malformed")
	`UTF8D_ASSERT_SAME(a_scalar_ok, !empty && !replaced, (code_point <= utf8d_pkg::MAX_CP) && !((code_point >= utf8d_pkg::SURR_LO) && (code_point <= utf8d_pkg::SURR_HI)) && (byte_count != 3'd0) && (byte_count <= 3'd4), "decoded word out of range")
	`UTF8D_ASSERT_NEXT(a_eos_flush, push && !full && end_of_stream, !pending, "sequence still pending after end of stream")
	`UTF8D_ASSERT_SAME(a_no_deq_empty, deq, stat.not_empty, "queue drained while empty")

endmodule
